// ----- src/set_assoc_lru_cache_model_macros.svh -----
// Assertion macros shared by the cache model RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every edge outside reset.
`define SALC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("salc check failed");
// Check a property on every edge, reset included.
`define SALC_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("salc check failed");
`else
`define SALC_ASSERT(label, clk, rst, prop)
`define SALC_ASSERT_ALL(label, clk, prop)
`endif
`endif

// ----- src/salc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache model.
// No dependencies.
package salc_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int TAG_W   = 64;
  localparam int DIRTY_W = 16;
  localparam int RANK_W  = 3;
  localparam int CNT_W   = 32;
  localparam int HELD_W  = 25;

  localparam logic [3:0]        BLOCK_BITS_LIMIT = 4'd12;
  localparam logic [RANK_W-1:0] RANK_MAX         = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // One line of a set
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [DIRTY_W-1:0] dirty;
    logic [RANK_W-1:0]  rank;
  } line_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

// ----- src/set_assoc_lru_cache_model.sv -----
// Top level of the set-associative LRU cache model.
// Depends on salc_pkg, salc_ctrl, salc_datapath and salc_ram.
//
//   port group   handshake               payload
//   in           in_valid / in_stall     op, address, size
//   out          out_valid / out_stall   hit .. dirty_bytes_now
//   cfg          cfg_we                  cfg_index, cfg_data
//
// For each item its set row is first read from the set memory; then all ways are
// compared, LRU ranks and dirty counts are updated and the row is written back.
// Per-row written flags stand in for clearing the set memory at reset.
// A new item is taken while a result beat waits; the update stalls on out_stall.
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [63:0]                  address,
  input  logic [7:0]                   size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic                         evicted,
  output logic [salc_pkg::DIRTY_W-1:0] evicted_dirty_bytes,
  output logic [salc_pkg::CNT_W-1:0]   hit_total,
  output logic [salc_pkg::CNT_W-1:0]   miss_total,
  output logic [salc_pkg::CNT_W-1:0]   eviction_total,
  output logic [salc_pkg::CNT_W-1:0]   dirty_evicted_total,
  output logic [salc_pkg::HELD_W-1:0]  dirty_bytes_now,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [3:0]                   cfg_data
);

  salc_pkg::cmd_t cmd;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  salc_datapath #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .op                  (op),
    .address             (address),
    .size                (size),
    .hit                 (hit),
    .evicted             (evicted),
    .evicted_dirty_bytes (evicted_dirty_bytes),
    .hit_total           (hit_total),
    .miss_total          (miss_total),
    .eviction_total      (eviction_total),
    .dirty_evicted_total (dirty_evicted_total),
    .dirty_bytes_now     (dirty_bytes_now)
  );

endmodule

// ----- src/salc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/salc_ctrl.sv -----
// Controller: sequences read, lookup/update and the output beat.
// Depends on salc_pkg and the assertion macro header.
`include "set_assoc_lru_cache_model_macros.svh"
module salc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output salc_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_stall    = (state != ST_IDLE);
  assign cmd.capture = in_valid && (state == ST_IDLE);
  assign cmd.commit  = (state == ST_LOOK) && !(out_valid && out_stall);

  // Advance state and output beat
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    case (state)
      ST_IDLE: begin
        if (out_valid && !out_stall) begin
          out_valid_next = 1'b0;
        end
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cmd.commit) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SALC_ASSERT(a_accept_to_look, clk, rst, cmd.capture |=> state == ST_LOOK)
  `SALC_ASSERT(a_commit_gives_beat, clk, rst, cmd.commit |=> out_valid && state == ST_IDLE)
  `SALC_ASSERT(a_no_commit_when_busy, clk, rst, cmd.commit |-> !(out_valid && out_stall))
  `SALC_ASSERT_ALL(a_reset_idle, clk, rst |=> state == ST_IDLE && !out_valid)

endmodule

// ----- src/salc_datapath.sv -----
// Datapath: configuration, set memory, tag compare, LRU update and totals.
// Depends on salc_pkg and salc_ram.
module salc_datapath #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  salc_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [3:0]                          cfg_data,
  input  logic                                op,
  input  logic [63:0]                         address,
  input  logic [7:0]                          size,
  output logic                                hit,
  output logic                                evicted,
  output logic [salc_pkg::DIRTY_W-1:0]        evicted_dirty_bytes,
  output logic [salc_pkg::CNT_W-1:0]          hit_total,
  output logic [salc_pkg::CNT_W-1:0]          miss_total,
  output logic [salc_pkg::CNT_W-1:0]          eviction_total,
  output logic [salc_pkg::CNT_W-1:0]          dirty_evicted_total,
  output logic [salc_pkg::HELD_W-1:0]         dirty_bytes_now
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH = 1 << SET_W;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W = MAX_WAYS * $bits(salc_pkg::line_t);
  localparam logic [4:0] WAYS_CAP = 5'(MAX_WAYS);
  localparam logic [3:0] SET_CAP  = 4'(MAX_SET_BITS);

  // Configuration registers
  logic [2:0] set_bits;
  logic [3:0] block_bits;
  logic [3:0] ways;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd0;
      block_bits <= 4'd6;
      ways       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::REG_SET_BITS:   set_bits   <= cfg_data[2:0];
        salc_pkg::REG_BLOCK_BITS: block_bits <= cfg_data;
        salc_pkg::REG_WAYS:       ways       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [3:0]  s_eff;
  logic [3:0]  b_eff;
  logic [4:0]  e_eff;
  logic [63:0] addr_sh;
  logic [SET_W-1:0] set_in;
  logic [63:0] tag_in;

  assign s_eff = ({1'b0, set_bits} > SET_CAP) ? SET_CAP : {1'b0, set_bits};
  assign b_eff = (block_bits > salc_pkg::BLOCK_BITS_LIMIT) ?
                 salc_pkg::BLOCK_BITS_LIMIT : block_bits;
  assign e_eff = (ways == 4'd0) ? 5'd1 :
                 (({1'b0, ways} > WAYS_CAP) ? WAYS_CAP : {1'b0, ways});
  assign addr_sh = address >> b_eff;
  assign set_in  = SET_W'(addr_sh & ~(64'hFFFF_FFFF_FFFF_FFFF << s_eff));
  assign tag_in  = address >> ({1'b0, b_eff} + {1'b0, s_eff});

  // Captured access
  logic             op_q;
  logic [7:0]       size_q;
  logic [SET_W-1:0] set_q;
  logic [63:0]      tag_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      size_q <= size;
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
  end

  // Row-written flags: an unwritten row reads as all zero
  logic [DEPTH-1:0] row_ok;

  // Set memory
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] wdata;

  salc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_q),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (set_in),
    .rdata (rdata)
  );

  // Lookup and update
  salc_pkg::line_t [MAX_WAYS-1:0] old_row;
  salc_pkg::line_t [MAX_WAYS-1:0] new_row;
  logic              hit_c;
  logic [WAY_W-1:0]  hitw;
  logic              has_empty;
  logic [WAY_W-1:0]  empw;
  logic [WAY_W-1:0]  vicw;
  logic [WAY_W-1:0]  selw;
  logic [3:0]        limit;
  logic              evict_c;
  logic [salc_pkg::DIRTY_W-1:0] old_dirty;
  logic [salc_pkg::DIRTY_W-1:0] new_dirty;
  logic [salc_pkg::DIRTY_W:0]   dirty_sum;
  logic [salc_pkg::DIRTY_W-1:0] ev_dirty;

  always_comb begin
    old_row   = row_ok[set_q] ? rdata : '0;
    hit_c     = 1'b0;
    hitw      = '0;
    has_empty = 1'b0;
    empw      = '0;
    // Lowest matching and lowest empty way win
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (5'(w) < e_eff) begin
        if (old_row[w].valid && old_row[w].tag == tag_q) begin
          hit_c = 1'b1;
          hitw  = WAY_W'(w);
        end
        if (!old_row[w].valid) begin
          has_empty = 1'b1;
          empw      = WAY_W'(w);
        end
      end
    end
    // Oldest way, ties to the lowest
    vicw = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (5'(w) < e_eff && old_row[w].rank > old_row[vicw].rank) begin
        vicw = WAY_W'(w);
      end
    end
    evict_c = !hit_c && !has_empty;
    selw    = hit_c ? hitw : (has_empty ? empw : vicw);
    limit   = (!hit_c && has_empty) ? 4'd8 : {1'b0, old_row[selw].rank};
    old_dirty = old_row[selw].dirty;
    dirty_sum = {1'b0, old_dirty} + {9'd0, size_q};
    if (hit_c) begin
      if (op_q) begin
        new_dirty = dirty_sum[salc_pkg::DIRTY_W] ? '1 : dirty_sum[salc_pkg::DIRTY_W-1:0];
      end else begin
        new_dirty = old_dirty;
      end
    end else begin
      new_dirty = op_q ? {8'd0, size_q} : '0;
    end
    ev_dirty = evict_c ? old_dirty : '0;
    // Age younger ways, place touched line
    new_row = old_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (5'(w) < e_eff) begin
        if (WAY_W'(w) == selw) begin
          new_row[w].valid = 1'b1;
          new_row[w].tag   = tag_q;
          new_row[w].dirty = new_dirty;
          new_row[w].rank  = '0;
        end else if (old_row[w].valid && {1'b0, old_row[w].rank} < limit &&
                     old_row[w].rank < salc_pkg::RANK_MAX) begin
          new_row[w].rank = old_row[w].rank + 3'd1;
        end
      end
    end
    wdata = ROW_W'(new_row);
  end

  // Totals and result beat
  logic [salc_pkg::CNT_W:0] ev_sum;
  assign ev_sum = {1'b0, dirty_evicted_total} + 33'(ev_dirty);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok              <= '0;
      hit_total           <= '0;
      miss_total          <= '0;
      eviction_total      <= '0;
      dirty_evicted_total <= '0;
      dirty_bytes_now     <= '0;
    end else if (cmd.commit) begin
      row_ok[set_q] <= 1'b1;
      if (hit_c) begin
        if (hit_total != '1) hit_total <= hit_total + 32'd1;
      end else begin
        if (miss_total != '1) miss_total <= miss_total + 32'd1;
      end
      if (evict_c) begin
        if (eviction_total != '1) eviction_total <= eviction_total + 32'd1;
        dirty_evicted_total <= ev_sum[salc_pkg::CNT_W] ? '1 :
                               ev_sum[salc_pkg::CNT_W-1:0];
      end
      dirty_bytes_now <= dirty_bytes_now - 25'(old_dirty) + 25'(new_dirty);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit                 <= hit_c;
      evicted             <= evict_c;
      evicted_dirty_bytes <= ev_dirty;
    end
  end

endmodule
